[hdl/virtual_parallel_port_bridge_top_assert.svh]
// Assertion macros shared by the bridge's checker.
`ifndef VIRTUAL_PARALLEL_PORT_BRIDGE_TOP_ASSERT_SVH
`define VIRTUAL_PARALLEL_PORT_BRIDGE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VPPB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vppb: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define VPPB_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vppb: assertion failed");

`endif

[hdl/vppb_pkg.sv]
// Types and constants shared by the parallel port bridge.
package vppb_pkg;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int LINES_W = 4;

   // Command codes of an input word.
   localparam logic [CMD_W-1:0] CMD_REMOTE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DATA    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_START   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_END     = 3'd5;

   // Flags ORed into the outgoing control byte.
   localparam logic [BYTE_W-1:0] FLAG_NONE   = 8'h00;
   localparam logic [BYTE_W-1:0] FLAG_STROBE = 8'h08;
   localparam logic [BYTE_W-1:0] FLAG_REPLY  = 8'h10;
   localparam logic [BYTE_W-1:0] FLAG_START  = 8'h40;
   localparam logic [BYTE_W-1:0] FLAG_END    = 8'h80;

   // Bit positions within a remote control byte.
   localparam int RCTL_ACK    = 3;
   localparam int RCTL_LOAD   = 4;
   localparam int RCTL_ASSIGN = 5;
   localparam int RCTL_SET    = 6;
   localparam int RCTL_CLEAR  = 7;

   // Line bit that carries the acknowledge.
   localparam int LINE_ACK = 3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] remote_ctl;
      logic [BYTE_W-1:0] remote_data;
      logic [BYTE_W-1:0] write_value;
      logic [BYTE_W-1:0] write_mask;
   } req_word_type;

   typedef struct packed {
      logic               send_valid;
      logic [BYTE_W-1:0]  send_ctl;
      logic [BYTE_W-1:0]  send_data;
      logic               ack_pulse;
      logic [LINES_W-1:0] line_status;
      logic [BYTE_W-1:0]  data_value;
   } rsp_word_type;

   // Contents of the input register as seen by the engine.
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_type;

endpackage

[hdl/vppb_if.sv]
// Handshake channels of the bridge: request words in, response words out.
interface vppb_req_if;
   logic                           valid;
   logic                           ready;
   logic [vppb_pkg::CMD_W-1:0]     command;
   logic [vppb_pkg::BYTE_W-1:0]    remote_ctl;
   logic [vppb_pkg::BYTE_W-1:0]    remote_data;
   logic [vppb_pkg::BYTE_W-1:0]    write_value;
   logic [vppb_pkg::BYTE_W-1:0]    write_mask;

   modport source (
      output valid, command, remote_ctl, remote_data, write_value, write_mask,
      input  ready
   );
   modport sink (
      input  valid, command, remote_ctl, remote_data, write_value, write_mask,
      output ready
   );
endinterface

interface vppb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           send_valid;
   logic [vppb_pkg::BYTE_W-1:0]    send_ctl;
   logic [vppb_pkg::BYTE_W-1:0]    send_data;
   logic                           ack_pulse;
   logic [vppb_pkg::LINES_W-1:0]   line_status;
   logic [vppb_pkg::BYTE_W-1:0]    data_value;

   modport source (
      output valid, send_valid, send_ctl, send_data, ack_pulse, line_status, data_value,
      input  ready
   );
   modport sink (
      input  valid, send_valid, send_ctl, send_data, ack_pulse, line_status, data_value,
      output ready
   );
endinterface

[hdl/virtual_parallel_port_bridge_top.sv]
// Parallel port bridge: local line and data registers mirrored to a remote peer.
//
// Request channel req_ch: one word per handshake carries a command (remote
// message, status write, data write, read, session start, session end) with
// its operands. Response channel rsp_ch: exactly one word per request, in
// order, giving the message to send to the peer (if any), the acknowledge
// pulse and the line bits and data latch after the request.
// csr_wr_en/csr_wr_data write the link-open bit; the user must write it only
// while the bridge holds no request in flight; the bridge does not enforce it.
// The accepting edge loads a request into the input register; once the result
// register can take it, the update logic carries it on into the result
// register, where its response is valid and waits to be taken.
// Throughput is one word per cycle while responses are taken, set by the single update stage.
// When the receiver stalls, the result register holds its word and the input
// register fills; req_ch.ready then falls until a response is taken.
// Reset clears both registers' valid bits, the link bit, the line bits, the
// data latch and the record of the last pair sent.
module virtual_parallel_port_bridge_top (
   input  logic            clock,
   input  logic            reset,
   vppb_req_if.sink        req_ch,
   vppb_rsp_if.source      rsp_ch,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   logic                   link_ff;
   logic                   advance;
   logic                   fire;
   vppb_pkg::req_word_type req_word;
   vppb_pkg::stage_type    stage;
   vppb_pkg::rsp_word_type result;
   vppb_pkg::rsp_word_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= 1'b0;
      end else if (csr_wr_en) begin
         link_ff <= csr_wr_data;
      end
   end

   assign req_word.command     = req_ch.command;
   assign req_word.remote_ctl  = req_ch.remote_ctl;
   assign req_word.remote_data = req_ch.remote_data;
   assign req_word.write_value = req_ch.write_value;
   assign req_word.write_mask  = req_ch.write_mask;

   vppb_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_word  (req_word),
      .advance   (advance),
      .stage     (stage)
   );

   // The state moves on exactly when a word passes into the result register.
   assign fire = stage.valid && advance;

   vppb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .link_open (link_ff),
      .word      (stage.word),
      .result    (result)
   );

   vppb_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_ch.send_valid  = rsp_word.send_valid;
   assign rsp_ch.send_ctl    = rsp_word.send_ctl;
   assign rsp_ch.send_data   = rsp_word.send_data;
   assign rsp_ch.ack_pulse   = rsp_word.ack_pulse;
   assign rsp_ch.line_status = rsp_word.line_status;
   assign rsp_ch.data_value  = rsp_word.data_value;

endmodule

[hdl/vppb_in_stage.sv]
// Input register of the bridge: holds one request word until the engine takes it.
module vppb_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vppb_pkg::req_word_type req_word,
   input  logic                   advance,
   output vppb_pkg::stage_type    stage
);

   logic                   valid_ff, valid_in;
   vppb_pkg::req_word_type word_ff;
   logic                   accept;

   // A held word leaves whenever the result register can take it.
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule

[hdl/vppb_engine.sv]
// Bridge state and the per-word update: line bits, data latch and last pair sent.
module vppb_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   link_open,
   input  vppb_pkg::req_word_type word,
   output vppb_pkg::rsp_word_type result
);

   logic [vppb_pkg::LINES_W-1:0] line_ff, line_in;
   logic [vppb_pkg::BYTE_W-1:0]  data_ff, data_in;
   logic [vppb_pkg::LINES_W-1:0] last_line_ff;
   logic [vppb_pkg::BYTE_W-1:0]  last_data_ff;

   logic [vppb_pkg::LINES_W-1:0] lines;
   logic [vppb_pkg::BYTE_W-1:0]  flags;
   logic [2:0]                   low_mask;
   logic                         do_send;
   logic                         forced;
   logic                         ack;
   logic                         differs;
   logic                         sent;

   always_comb begin
      lines    = line_ff;
      data_in  = data_ff;
      flags    = vppb_pkg::FLAG_NONE;
      do_send  = 1'b0;
      forced   = 1'b1;
      ack      = 1'b0;
      low_mask = word.write_mask[2:0];
      case (word.command)
         vppb_pkg::CMD_REMOTE: begin
            if (word.remote_ctl != '0) begin
               if (word.remote_ctl[vppb_pkg::RCTL_LOAD]) begin
                  data_in = word.remote_data;
               end
               if (word.remote_ctl[vppb_pkg::RCTL_ASSIGN]) begin
                  lines[2:0] = word.remote_ctl[2:0];
               end else if (word.remote_ctl[vppb_pkg::RCTL_SET]) begin
                  lines[2:0] = lines[2:0] | word.remote_ctl[2:0];
               end else if (word.remote_ctl[vppb_pkg::RCTL_CLEAR]) begin
                  lines[2:0] = lines[2:0] & ~word.remote_ctl[2:0];
               end
               if (word.remote_ctl[vppb_pkg::RCTL_ACK]) begin
                  ack                      = 1'b1;
                  lines[vppb_pkg::LINE_ACK] = 1'b1;
               end
            end
            // A remote word is answered whenever the link is open, even when it changed nothing.
            do_send = 1'b1;
            flags   = vppb_pkg::FLAG_REPLY;
         end
         vppb_pkg::CMD_STATUS: begin
            lines[2:0] = (word.write_value[2:0] & low_mask) | (lines[2:0] & ~low_mask);
            do_send    = 1'b1;
            forced     = 1'b0;
         end
         vppb_pkg::CMD_DATA: begin
            data_in = (word.write_value & word.write_mask) | (data_ff & ~word.write_mask);
            do_send = 1'b1;
            flags   = vppb_pkg::FLAG_STROBE;
         end
         vppb_pkg::CMD_START: begin
            do_send = 1'b1;
            flags   = vppb_pkg::FLAG_START;
         end
         vppb_pkg::CMD_END: begin
            do_send = 1'b1;
            flags   = vppb_pkg::FLAG_END;
         end
         default: begin
            do_send = 1'b0;
         end
      endcase

      // A status write is dropped when it would repeat the last pair sent.
      differs = (lines != last_line_ff) || (data_in != last_data_ff);
      sent    = link_open && do_send && (forced || differs);

      // The acknowledge goes out in the reply and is then withdrawn.
      line_in = lines;
      if (ack) begin
         line_in[vppb_pkg::LINE_ACK] = 1'b0;
      end

      result.send_valid  = sent;
      result.send_ctl    = sent ? ({{(vppb_pkg::BYTE_W-vppb_pkg::LINES_W){1'b0}}, lines} | flags)
                                : '0;
      result.send_data   = sent ? data_in : '0;
      result.ack_pulse   = ack;
      result.line_status = line_in;
      result.data_value  = data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         data_ff      <= '0;
         last_line_ff <= '0;
         last_data_ff <= '0;
      end else if (fire) begin
         line_ff <= line_in;
         data_ff <= data_in;
         if (sent) begin
            last_line_ff <= lines;
            last_data_ff <= data_in;
         end
      end
   end

endmodule

[hdl/vppb_out_stage.sv]
// Result register of the bridge: holds a response word until the receiver takes it.
module vppb_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vppb_pkg::rsp_word_type result,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vppb_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff, valid_in;
   vppb_pkg::rsp_word_type word_ff;

   // The register can take a new word when empty or when its word leaves now.
   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

[hdl/vppb_checker.sv]
// Port-level checks of the bridge, bound to its top level.
`include "virtual_parallel_port_bridge_top_assert.svh"

module vppb_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_send_valid,
   input  logic [vppb_pkg::BYTE_W-1:0]      rsp_send_ctl,
   input  logic [vppb_pkg::BYTE_W-1:0]      rsp_send_data,
   input  logic                             rsp_ack_pulse,
   input  logic [vppb_pkg::LINES_W-1:0]     rsp_line_status,
   input  logic [vppb_pkg::BYTE_W-1:0]      rsp_data_value,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data
);

   // Copy of the link bit as written through the register port.
   logic link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= 1'b0;
      end else if (csr_wr_en) begin
         link_ff <= csr_wr_data;
      end
   end

   // A stalled response word holds still.
   `VPPB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_send_ctl) && $stable(rsp_send_data)
      && $stable(rsp_line_status) && $stable(rsp_data_value))

   // Nothing is sent to the peer while the link is closed.
   `VPPB_ASSERT_IMP(a_closed_silent, rsp_valid && !link_ff, !rsp_send_valid)

   // An acknowledge on an open link always goes out in a reply with the ack bit.
   `VPPB_ASSERT_IMP(a_ack_reply, rsp_valid && rsp_ack_pulse && link_ff,
      rsp_send_valid && rsp_send_ctl[3] && rsp_send_ctl[4])

   // The response to a taken request reaches the result register.
   `VPPB_ASSERT_IMP(a_latency, req_valid && req_ready, ##2 rsp_valid)

endmodule

bind virtual_parallel_port_bridge_top vppb_checker u_vppb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_send_valid  (rsp_ch.send_valid),
   .rsp_send_ctl    (rsp_ch.send_ctl),
   .rsp_send_data   (rsp_ch.send_data),
   .rsp_ack_pulse   (rsp_ch.ack_pulse),
   .rsp_line_status (rsp_ch.line_status),
   .rsp_data_value  (rsp_ch.data_value),
   .csr_wr_en       (csr_wr_en),
   .csr_wr_data     (csr_wr_data)
);
